// ===== hdl/ggpw_pkg.sv =====
// Shared types and constants for the greedy grid path walker.
// No dependencies; imported by greedy_grid_path_walker, ggpw_path_checker and tb.
`default_nettype none

package ggpw_pkg;

  // Fixed field widths of the channel words
  localparam int unsigned WEIGHT_W = 16;
  localparam int unsigned COORD_W  = 5;
  localparam int unsigned SUM_W    = 22;
  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = COORD_W;
  localparam logic [CFG_IDX_W-1:0] CFG_LAST_ROW = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LAST_COL = 2'd1;
  localparam logic [COORD_W-1:0]   CFG_RESET    = 5'd31;

  // Input word: one grid cell
  typedef struct packed {
    logic [WEIGHT_W-1:0] cell_weight;
    logic                last_cell;
  } in_word_t;

  // Output word: one visited cell
  typedef struct packed {
    logic [COORD_W-1:0] path_row;
    logic [COORD_W-1:0] path_col;
    logic [SUM_W-1:0]   path_total;
    logic               last_step;
  } out_word_t;

endpackage

`default_nettype wire

// ===== hdl/ggpw_store.sv =====
// Grid weight store: single write port, single read port with registered data.
// Uses no package items; instantiated by greedy_grid_path_walker.
`default_nettype none

module ggpw_store #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10,
  parameter int unsigned DW    = 16
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [DW-1:0] wdata_i,
  input  wire logic          re_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_q;

  // Write and registered read; contents undefined until written
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== hdl/greedy_grid_path_walker.sv =====
// Top level of the greedy grid path walker: load sequencer, walk sequencer, output register.
// Depends on ggpw_pkg and ggpw_store.
//
// Cells are loaded row-major, one word per cycle while idle, into a store with one write and
// one read port. A word with last_cell set starts the walk from (0,0) to (last_row_index,
// last_col_index); in_stall_o stays high until the final path word has been put in the
// output register. The walk runs on one store read port: each visited cell costs one read,
// one saturating add and one emit state, where an output stall holds it; a cell with a free
// choice of diagonal, right or down costs three more reads. A walk over an R x C grid visits
// at most R+C-1 cells. The store needs no clearing pass; cells must be written before a walk.
`default_nettype none

module greedy_grid_path_walker #(
  parameter int unsigned MAX_ROWS    = 32,
  parameter int unsigned MAX_COLS    = 32,
  parameter int unsigned WEIGHT_BITS = 16
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  // cell input
  input  wire logic                                 in_valid_i,
  output logic                                      in_stall_o,
  input  wire ggpw_pkg::in_word_t                   in_word_i,
  // path output
  output logic                                      out_valid_o,
  input  wire logic                                 out_stall_i,
  output ggpw_pkg::out_word_t                       out_word_o,
  // configuration
  input  wire logic                                 cfg_we_i,
  input  wire logic [ggpw_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  wire logic [ggpw_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  import ggpw_pkg::*;

  localparam int unsigned DEPTH   = MAX_ROWS * MAX_COLS;
  localparam int unsigned AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned STORE_W = (WEIGHT_BITS < WEIGHT_W) ? WEIGHT_BITS : WEIGHT_W;

  // Sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_ACC  = 3'd2;
  localparam logic [2:0] S_EMIT = 3'd3;
  localparam logic [2:0] S_RDR  = 3'd4;
  localparam logic [2:0] S_RDW  = 3'd5;
  localparam logic [2:0] S_DEC  = 3'd6;

  // Move directions
  localparam logic [1:0] MV_DIAG  = 2'd0;
  localparam logic [1:0] MV_RIGHT = 2'd1;
  localparam logic [1:0] MV_DOWN  = 2'd2;

  logic [2:0]         state_q, state_d;
  logic [COORD_W-1:0] cfg_row_q, cfg_col_q;
  logic [AW-1:0]      load_q, load_d;
  logic [COORD_W-1:0] row_q, row_d, col_q, col_d;
  logic [AW-1:0]      addr_q, addr_d;
  logic [SUM_W-1:0]   sum_q, sum_d;
  logic [STORE_W-1:0] best_q, best_d;
  logic [1:0]         dir_q, dir_d;
  logic               out_valid_q, out_valid_d;
  out_word_t          out_word_q, out_word_d;

  logic [COORD_W-1:0] lr, lc;
  logic [AW-1:0]      row_step, diag_step;
  logic               mem_we, rd_en;
  logic [AW-1:0]      rd_addr;
  logic [STORE_W-1:0] rd_data;
  logic               rd_lt;
  logic [SUM_W:0]     sum_ext;
  logic               at_end, out_free, mv_go;
  logic [1:0]         mv_dir;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_row_q <= CFG_RESET;
      cfg_col_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_LAST_ROW: cfg_row_q <= cfg_data_i;
        CFG_LAST_COL: cfg_col_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Clamp dimensions to the store geometry
  assign lr = (int'(cfg_row_q) > int'(MAX_ROWS) - 1) ? COORD_W'(MAX_ROWS - 1) : cfg_row_q;
  assign lc = (int'(cfg_col_q) > int'(MAX_COLS) - 1) ? COORD_W'(MAX_COLS - 1) : cfg_col_q;

  // Address offsets of the down and diagonal neighbors
  assign row_step  = AW'(lc) + AW'(1);
  assign diag_step = row_step + AW'(1);

  // Shared compare and saturating add
  assign rd_lt   = rd_data < best_q;
  assign sum_ext = {1'b0, sum_q} + (SUM_W + 1)'(rd_data);

  assign at_end   = (row_q == lr) && (col_q == lc);
  assign out_free = !out_valid_q || !out_stall_i;
  assign mem_we   = (state_q == S_IDLE) && in_valid_i;

  ggpw_store #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .DW    (STORE_W)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (load_q),
    .wdata_i (in_word_i.cell_weight[STORE_W-1:0]),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  // Sequencer
  always_comb begin
    state_d     = state_q;
    load_d      = load_q;
    row_d       = row_q;
    col_d       = col_q;
    addr_d      = addr_q;
    sum_d       = sum_q;
    best_d      = best_q;
    dir_d       = dir_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_word_d  = out_word_q;
    rd_en       = 1'b0;
    rd_addr     = addr_q;
    mv_go       = 1'b0;
    mv_dir      = MV_DOWN;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (in_word_i.last_cell) begin
            load_d  = '0;
            row_d   = '0;
            col_d   = '0;
            addr_d  = '0;
            sum_d   = '0;
            state_d = S_RD;
          end else if (load_q == AW'(DEPTH - 1)) begin
            load_d = '0;
          end else begin
            load_d = load_q + AW'(1);
          end
        end
      end
      S_RD: begin
        rd_en   = 1'b1;
        state_d = S_ACC;
      end
      S_ACC: begin
        sum_d   = (sum_ext > {1'b0, SUM_MAX}) ? SUM_MAX : sum_ext[SUM_W-1:0];
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_d           = 1'b1;
          out_word_d.path_row   = row_q;
          out_word_d.path_col   = col_q;
          out_word_d.path_total = sum_q;
          out_word_d.last_step  = at_end;
          if (at_end) begin
            state_d = S_IDLE;
          end else if (row_q == lr) begin
            mv_go  = 1'b1;
            mv_dir = MV_RIGHT;
          end else if (col_q == lc) begin
            mv_go  = 1'b1;
            mv_dir = MV_DOWN;
          end else begin
            rd_en   = 1'b1;
            rd_addr = addr_q + diag_step;
            state_d = S_RDR;
          end
        end
      end
      S_RDR: begin
        // diagonal weight arrives
        best_d  = rd_data;
        dir_d   = MV_DIAG;
        rd_en   = 1'b1;
        rd_addr = addr_q + AW'(1);
        state_d = S_RDW;
      end
      S_RDW: begin
        // right weight arrives; strictly smaller beats diagonal
        if (rd_lt) begin
          best_d = rd_data;
          dir_d  = MV_RIGHT;
        end
        rd_en   = 1'b1;
        rd_addr = addr_q + row_step;
        state_d = S_DEC;
      end
      S_DEC: begin
        // down weight arrives; wins only when strictly smallest
        mv_go  = 1'b1;
        mv_dir = rd_lt ? MV_DOWN : dir_q;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // Step to the chosen neighbor, then fetch its weight
    if (mv_go) begin
      case (mv_dir)
        MV_DIAG: begin
          row_d  = row_q + COORD_W'(1);
          col_d  = col_q + COORD_W'(1);
          addr_d = addr_q + diag_step;
        end
        MV_RIGHT: begin
          col_d  = col_q + COORD_W'(1);
          addr_d = addr_q + AW'(1);
        end
        default: begin
          row_d  = row_q + COORD_W'(1);
          addr_d = addr_q + row_step;
        end
      endcase
      state_d = S_RD;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      load_q      <= '0;
      row_q       <= '0;
      col_q       <= '0;
      addr_q      <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      load_q      <= load_d;
      row_q       <= row_d;
      col_q       <= col_d;
      addr_q      <= addr_d;
      sum_q       <= sum_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    best_q     <= best_d;
    dir_q      <= dir_d;
    out_word_q <= out_word_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

`default_nettype wire

// ===== verif/ggpw_path_checker.sv =====
`timescale 1ns / 1ps
// Path checker for the greedy grid path walker: mirrors the grid store and the
// dimension registers, predicts every path word and compares it with the output.
// Depends on ggpw_pkg.
module ggpw_path_checker (
  input  logic                 clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  ggpw_pkg::in_word_t  in_word_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  ggpw_pkg::out_word_t out_word_i,
  input  logic                cfg_we_i,
  input  logic [ggpw_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ggpw_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output int unsigned         fail_count_o,
  output int unsigned         words_waiting_o
);
  import ggpw_pkg::*;

  localparam int unsigned STORE_CELLS = 1024;

  // Shadow of the block state
  logic [WEIGHT_W-1:0] cell_mem [STORE_CELLS];
  logic [9:0]          load_ptr;
  logic [COORD_W-1:0]  lim_row;
  logic [COORD_W-1:0]  lim_col;

  out_word_t   path_due [$];
  out_word_t   due_w;
  int unsigned fails;

  function automatic logic [WEIGHT_W-1:0] weight_at(input int unsigned r,
                                                    input int unsigned c);
    return cell_mem[(r * (int'(lim_col) + 1) + c) % STORE_CELLS];
  endfunction

  // Greedy walk from (0,0) to (lim_row, lim_col), queuing one word per visited cell
  task automatic walk_path();
    logic [COORD_W-1:0]  r;
    logic [COORD_W-1:0]  c;
    logic [WEIGHT_W-1:0] w_diag;
    logic [WEIGHT_W-1:0] w_right;
    logic [WEIGHT_W-1:0] w_down;
    int unsigned         total;
    out_word_t           w;
    r = '0;
    c = '0;
    total = weight_at(0, 0);
    while (r != lim_row || c != lim_col) begin
      w.path_row   = r;
      w.path_col   = c;
      w.path_total = SUM_W'(total);
      w.last_step  = 1'b0;
      path_due = {path_due, w};
      if (r == lim_row) begin
        c++;
      end else if (c == lim_col) begin
        r++;
      end else begin
        w_diag  = weight_at(int'(r) + 1, int'(c) + 1);
        w_right = weight_at(int'(r), int'(c) + 1);
        w_down  = weight_at(int'(r) + 1, int'(c));
        // ties: diagonal, then right, then down
        if (w_diag <= w_right && w_diag <= w_down) begin
          r++;
          c++;
        end else if (w_right <= w_down) begin
          c++;
        end else begin
          r++;
        end
      end
      total = total + weight_at(int'(r), int'(c));
      if (total > SUM_MAX) total = SUM_MAX;
    end
    w.path_row   = r;
    w.path_col   = c;
    w.path_total = SUM_W'(total);
    w.last_step  = 1'b1;
    path_due = {path_due, w};
  endtask

  task automatic flag_fail(input string what);
    fails++;
    if (fails <= 10) $display("%t: %s", $realtime, what);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      path_due.delete();
      load_ptr        = '0;
      lim_row         = CFG_RESET;
      lim_col         = CFG_RESET;
      fails           = 0;
      fail_count_o    <= 0;
      words_waiting_o <= 0;
    end else begin
      // output side: compare against the oldest expected word
      if (out_valid_i && !out_stall_i) begin
        if (path_due.size() == 0) begin
          flag_fail($sformatf("unexpected path word row %0d col %0d total %0d last %0b",
                              out_word_i.path_row, out_word_i.path_col,
                              out_word_i.path_total, out_word_i.last_step));
        end else begin
          due_w = path_due.pop_front();
          if (due_w !== out_word_i) begin
            flag_fail($sformatf({"path word mismatch: exp row %0d col %0d total %0d last %0b,",
                                 " got row %0d col %0d total %0d last %0b"},
                                due_w.path_row, due_w.path_col, due_w.path_total,
                                due_w.last_step, out_word_i.path_row, out_word_i.path_col,
                                out_word_i.path_total, out_word_i.last_step));
          end
        end
      end
      // dimension registers; other indexes are ignored
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_LAST_ROW: lim_row = cfg_data_i;
          CFG_LAST_COL: lim_col = cfg_data_i;
          default: ;
        endcase
      end
      // input side: store the cell, walk on the marked one
      if (in_valid_i && !in_stall_i) begin
        cell_mem[load_ptr] = in_word_i.cell_weight;
        load_ptr = load_ptr + 10'd1;
        if (in_word_i.last_cell) begin
          walk_path();
          load_ptr = '0;
        end
      end
      fail_count_o    <= fails;
      words_waiting_o <= path_due.size();
    end
  end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// Testbench top for greedy_grid_path_walker: drives grids, dimension writes and
// output stalls; ggpw_path_checker predicts and checks. Depends on ggpw_pkg.
module tb;
  import ggpw_pkg::*;

  localparam int unsigned STORE_CELLS   = 1024;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned PHASE_CELLS   = 50;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

  typedef logic [WEIGHT_W-1:0] weight_q_t [$];
  typedef enum int unsigned {W_TIES, W_EXTREME, W_BYTE, W_FULL} weight_mix_e;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  in_word_t              in_word_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  out_word_t             out_word_o;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  int unsigned fail_count;
  int unsigned words_waiting;

  // stimulus state
  int unsigned        idle_pct = 0;
  int unsigned        stall_pct = 0;
  int unsigned        hi_water = 0;  // store entries written since reset, from 0 up
  logic [COORD_W-1:0] rows_last = CFG_RESET;
  logic [COORD_W-1:0] cols_last = CFG_RESET;

  greedy_grid_path_walker u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  ggpw_path_checker u_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .in_word_i       (in_word_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_word_i      (out_word_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .fail_count_o    (fail_count),
    .words_waiting_o (words_waiting)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // receiver back-pressure
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < stall_pct);
  end

  // one cell word, with random sender gaps ahead of it
  task automatic push_cell(input in_word_t w);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // whole grid, mark on the last cell
  task automatic feed_grid(input weight_q_t cells);
    in_word_t w;
    foreach (cells[i]) begin
      w.cell_weight = cells[i];
      w.last_cell   = (i == cells.size() - 1);
      push_cell(w);
    end
    if (cells.size() > hi_water) begin
      hi_water = (cells.size() > STORE_CELLS) ? STORE_CELLS : cells.size();
    end
  endtask

  // drop valid and wait until every path word is out and the walk has wound down
  task automatic quiesce();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (words_waiting != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
  endtask

  task automatic set_dims(input logic [COORD_W-1:0] r, input logic [COORD_W-1:0] c);
    quiesce();
    write_reg(CFG_LAST_ROW, r);
    write_reg(CFG_LAST_COL, c);
    cfg_we_i  <= 1'b0;
    rows_last = r;
    cols_last = c;
  endtask

  function automatic logic [WEIGHT_W-1:0] draw_weight(input weight_mix_e mix);
    case (mix)
      W_TIES:    return WEIGHT_W'($urandom_range(0, 3));
      W_EXTREME: return $urandom_range(0, 1) ? '1 : '0;
      W_BYTE:    return WEIGHT_W'($urandom_range(0, 255));
      default:   return WEIGHT_W'($urandom());
    endcase
  endfunction

  initial begin
    int unsigned idle_plan [4];
    int unsigned stall_plan [4];
    int unsigned phase_cells;
    int unsigned need;
    int unsigned n_cells;
    int unsigned roll;
    bit          new_phase;
    weight_mix_e mix;
    weight_q_t   grid;

    idle_plan  = '{0, 81, 0, 37};
    stall_plan = '{0, 0, 81, 37};
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // single cell grid, then writes to unused indexes must leave it 1x1
    set_dims(5'd0, 5'd0);
    feed_grid('{16'hFFFF});
    quiesce();
    write_reg(CFG_SPARE_LO, 5'd31);
    write_reg(CFG_SPARE_HI, 5'd0);
    cfg_we_i <= 1'b0;
    feed_grid('{16'h0000});

    // single row walks right only, single column walks down only
    set_dims(5'd0, 5'd3);
    feed_grid('{16'd1, 16'd2, 16'd3, 16'd4});
    set_dims(5'd3, 5'd0);
    feed_grid('{16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF});

    // 2x2 tie breaks: all equal, right over down, down alone smallest
    set_dims(5'd1, 5'd1);
    feed_grid('{16'd9, 16'd4, 16'd4, 16'd4});
    feed_grid('{16'd9, 16'd3, 16'd3, 16'd5});
    feed_grid('{16'd9, 16'd5, 16'd2, 16'd8});
    // only the marked cell: the rest of the grid is left from before
    feed_grid('{16'd7});

    // largest grid, loaded past the end of the store so the load address wraps
    set_dims(5'd31, 5'd31);
    grid.delete();
    repeat (STORE_CELLS + 6) grid = {grid, WEIGHT_W'($urandom())};
    feed_grid(grid);

    // random grids under each mix of sender idling and output stalls
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct    = idle_plan[ph];
      stall_pct   = stall_plan[ph];
      phase_cells = 0;
      new_phase   = 1'b1;
      while (phase_cells < PHASE_CELLS) begin
        if (new_phase || $urandom_range(0, 2) == 0) begin
          set_dims(($urandom_range(0, 15) == 0) ? COORD_W'($urandom_range(0, 31))
                                                : COORD_W'($urandom_range(0, 7)),
                   ($urandom_range(0, 15) == 0) ? COORD_W'($urandom_range(0, 31))
                                                : COORD_W'($urandom_range(0, 7)));
          new_phase = 1'b0;
        end
        need = (int'(rows_last) + 1) * (int'(cols_last) + 1);
        roll = $urandom_range(0, 7);
        // mostly exact grids; some short (stale tail) and some overlong
        if (roll == 0 && need > 1 && hi_water >= need) begin
          n_cells = $urandom_range(1, need - 1);
        end else if (roll == 1) begin
          n_cells = need + $urandom_range(1, 6);
        end else begin
          n_cells = need;
        end
        mix = weight_mix_e'($urandom_range(0, 3));
        grid.delete();
        repeat (n_cells) grid = {grid, draw_weight(mix)};
        feed_grid(grid);
        phase_cells += n_cells;
      end
    end

    quiesce();
    repeat (20) @(posedge clk_i);
    if (fail_count == 0 && words_waiting == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
